>>> rtl/event_timer_table_core_macros.svh
// Assertion macros shared by the event timer table checker.
// Depends on a clk and an active-low rst_n in the scope that uses them.
`ifndef EVENT_TIMER_TABLE_CORE_MACROS_SVH
`define EVENT_TIMER_TABLE_CORE_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ETT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ett_checker: same-cycle property failed");

// Next-cycle implication, held off during reset.
`define ETT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ett_checker: next-cycle property failed");

`endif

>>> rtl/ett_pkg.sv
// Shared types and constants of the event timer table.
// No dependencies; imported by ett_ctrl, ett_datapath and event_timer_table_core.
`default_nettype none

package ett_pkg;

    localparam int NUM_SLOTS   = 8;
    localparam int IDX_W       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int MASK_SLOTS  = (NUM_SLOTS < 8) ? NUM_SLOTS : 8;

    // request codes
    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_ARM  = 2'd1;
    localparam logic [1:0] REQ_DONE = 2'd2;
    localparam logic [1:0] REQ_OFF  = 2'd3;

    // slot status codes
    localparam logic [1:0] ST_OFF     = 2'd0;
    localparam logic [1:0] ST_WAITING = 2'd1;
    localparam logic [1:0] ST_READY   = 2'd2;
    localparam logic [1:0] ST_DONE    = 2'd3;

    // floor of the signed remaining time
    localparam logic signed [15:0] TIME_MIN = 16'sh8000;

    typedef struct packed {
        logic load;     // capture request word, restart scan
        logic step;     // process the slot under the scan index
        logic publish;  // load the result register
    } ett_cmd_t;

    typedef struct packed {
        logic last;     // scan index sits on the final slot
    } ett_sts_t;

endpackage

`default_nettype wire

>>> rtl/ett_req_if.sv
// Request channel: valid/ready handshake carrying one request word.
// No dependencies.
`default_nettype none

interface ett_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [2:0]  slot;
    logic [15:0] tick_count;
    logic        periodic;
    logic [14:0] period;

    modport source (output valid, output req_type, output slot, output tick_count,
                    output periodic, output period, input ready);
    modport sink   (input valid, input req_type, input slot, input tick_count,
                    input periodic, input period, output ready);
endinterface

`default_nettype wire

>>> rtl/ett_rsp_if.sv
// Response channel: valid/ready handshake carrying one result word.
// No dependencies.
`default_nettype none

interface ett_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  ready_mask;
    logic [14:0] next_wait;

    modport source (output valid, output ready_mask, output next_wait, input ready);
    modport sink   (input valid, input ready_mask, input next_wait, output ready);
endinterface

`default_nettype wire

>>> rtl/ett_ctrl.sv
// Sequencing controller of the event timer table.
// Depends on ett_pkg for command and status types.
`default_nettype none

module ett_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output ett_pkg::ett_cmd_t      cmd,
    input  wire ett_pkg::ett_sts_t sts
);
    import ett_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.step = 1'b1;
                if (sts.last)
                begin
                    if (out_free)
                    begin
                        cmd.publish = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.publish || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/ett_datapath.sv
// Slot table, per-slot update unit and running minimum of the timer table.
// Depends on ett_pkg for codes, sizes and command types.
`default_nettype none

module ett_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ett_pkg::ett_cmd_t cmd,
    output ett_pkg::ett_sts_t      sts,
    input  wire logic [1:0]        req_type,
    input  wire logic [2:0]        slot,
    input  wire logic [15:0]       tick_count,
    input  wire logic              periodic,
    input  wire logic [14:0]       period,
    output logic [7:0]             ready_mask,
    output logic [14:0]            next_wait
);
    import ett_pkg::*;

    // captured request word
    logic [1:0]  req_type_reg;
    logic [2:0]  slot_reg;
    logic [15:0] tick_count_reg;
    logic        periodic_reg;
    logic [14:0] period_reg;

    // slot table
    logic [1:0]         status_reg  [NUM_SLOTS];
    logic [1:0]         status_next [NUM_SLOTS];
    logic signed [15:0] time_reg    [NUM_SLOTS];
    logic               per_reg     [NUM_SLOTS];
    logic [14:0]        period_tbl_reg [NUM_SLOTS];

    logic [IDX_W-1:0] idx_reg;
    logic [14:0]      best_reg, best_fold;
    logic [7:0]       ready_mask_reg, mask_next;
    logic [14:0]      next_wait_reg;

    // current slot and its new contents
    logic [1:0]         cur_st, new_st;
    logic signed [15:0] cur_tm, new_tm;
    logic               new_per;
    logic [14:0]        new_pd;
    logic signed [17:0] diff;
    logic               hit;

    assign sts.last = (idx_reg == IDX_W'(NUM_SLOTS - 1));
    assign cur_st   = status_reg[idx_reg];
    assign cur_tm   = time_reg[idx_reg];
    assign hit      = (int'(slot_reg) == int'(idx_reg));
    assign diff     = {cur_tm[15], cur_tm[15], cur_tm} - $signed({2'b00, tick_count_reg});

    always_comb
    begin
        new_st  = cur_st;
        new_tm  = cur_tm;
        new_per = per_reg[idx_reg];
        new_pd  = period_tbl_reg[idx_reg];
        if (req_type_reg == REQ_TICK)
        begin
            if (cur_st == ST_DONE)
            begin
                new_tm = per_reg[idx_reg] ? $signed({1'b0, period_tbl_reg[idx_reg]}) : 16'sd0;
                new_st = (new_tm <= 16'sd0) ? ST_READY : ST_WAITING;
            end
            else if (cur_st != ST_OFF)
            begin
                if (per_reg[idx_reg])
                begin
                    new_tm = (diff < 18'(TIME_MIN)) ? TIME_MIN : diff[15:0];
                end
                else
                begin
                    new_tm = 16'sd0;
                end
                if (new_tm <= 16'sd0)
                begin
                    new_st = ST_READY;
                end
            end
        end
        else if (hit)
        begin
            unique case (req_type_reg)
                REQ_ARM:
                begin
                    new_st  = ST_WAITING;
                    new_per = periodic_reg;
                    new_pd  = period_reg;
                    new_tm  = $signed({1'b0, period_reg});
                end
                REQ_DONE:
                begin
                    if (cur_st != ST_OFF)
                    begin
                        new_st = ST_DONE;
                    end
                end
                REQ_OFF:
                begin
                    new_st = ST_OFF;
                end
                default:
                begin
                    new_st = cur_st;
                end
            endcase
        end
    end

    // write back the visited slot only
    always_comb
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            status_next[i] = status_reg[i];
        end
        if (cmd.step)
        begin
            status_next[idx_reg] = new_st;
        end
    end

    // fold the visited slot into the least positive waiting time
    always_comb
    begin
        best_fold = best_reg;
        if (cmd.step && new_st == ST_WAITING && new_tm > 16'sd0
            && (best_reg == 15'd0 || new_tm[14:0] < best_reg))
        begin
            best_fold = new_tm[14:0];
        end
    end

    always_comb
    begin
        mask_next = '0;
        for (int i = 0; i < MASK_SLOTS; i++)
        begin
            mask_next[i] = (status_next[i] == ST_READY);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                status_reg[i] <= ST_OFF;
            end
            idx_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                status_reg[i] <= status_next[i];
            end
            if (cmd.load)
            begin
                idx_reg <= '0;
            end
            else if (cmd.step && !sts.last)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_type_reg   <= req_type;
            slot_reg       <= slot;
            tick_count_reg <= tick_count;
            periodic_reg   <= periodic;
            period_reg     <= period;
            best_reg       <= '0;
        end
        else
        begin
            best_reg <= best_fold;
        end
        if (cmd.step)
        begin
            time_reg[idx_reg]       <= new_tm;
            per_reg[idx_reg]        <= new_per;
            period_tbl_reg[idx_reg] <= new_pd;
        end
        if (cmd.publish)
        begin
            ready_mask_reg <= mask_next;
            next_wait_reg  <= best_fold;
        end
    end

    assign ready_mask = ready_mask_reg;
    assign next_wait  = next_wait_reg;

endmodule

`default_nettype wire

>>> rtl/event_timer_table_core.sv
// Event timer table top level: once a request word is taken, the scan in ett_datapath visits
// every slot in turn, and the result word is published when the scan ends and the output
// register is free; only then is the next request taken, one request word at a time.
// A stalled result sits in the output register; a new request is taken meanwhile.
// rst_n (async, active low) turns every slot off and idles the sequencer at once.
// Depends on ett_pkg, ett_req_if, ett_rsp_if, ett_ctrl and ett_datapath.
`default_nettype none

module event_timer_table_core (
    input  wire logic clk,
    input  wire logic rst_n,
    ett_req_if.sink   req,
    ett_rsp_if.source rsp
);
    import ett_pkg::*;

    ett_cmd_t cmd;
    ett_sts_t sts;

    // Sequencer: take a request word, step the scan index over every slot,
    // then hand the result to the output register once it is free.
    ett_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Slot table: each scan step updates one slot (tick, or the addressed
    // arm/done/off) and folds its new time into the running minimum.
    ett_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .req_type   (req.req_type),
        .slot       (req.slot),
        .tick_count (req.tick_count),
        .periodic   (req.periodic),
        .period     (req.period),
        .ready_mask (rsp.ready_mask),
        .next_wait  (rsp.next_wait)
    );

endmodule

`default_nettype wire

>>> rtl/ett_checker.sv
// Port-level checker of the event timer table, bound to the top level.
// Depends on event_timer_table_core_macros.svh.
`default_nettype none

`include "event_timer_table_core_macros.svh"

module ett_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_valid,
    input wire logic        req_ready,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic [7:0]  rsp_ready_mask,
    input wire logic [14:0] rsp_next_wait
);

    // hold a stalled result word
    `ETT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
    `ETT_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_ready_mask) && $stable(rsp_next_wait))
    // one request word at a time
    `ETT_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready)
    // no result in the cycle straight after a request is taken
    `ETT_ASSERT_NEXT(a_no_early_rsp, req_valid && req_ready, !$rose(rsp_valid))
    // return to idle only with the result published
    `ETT_ASSERT_NOW(a_idle_published, $rose(req_ready), rsp_valid)

endmodule

bind event_timer_table_core ett_checker u_ett_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_ready_mask (rsp.ready_mask),
    .rsp_next_wait  (rsp.next_wait)
);

`default_nettype wire
